/* hdl/lpbf_pkg.sv */
// ----------------------------------------------------------------------------
// lpbf_pkg
// shared types, constants and register map of the broadcast page formatter
// ----------------------------------------------------------------------------
package lpbf_pkg;

  localparam int COMMON_INTERVAL = 40;
  localparam int SLOT_COUNT      = 2 * COMMON_INTERVAL;
  localparam int SLOT_W          = $clog2(SLOT_COUNT);

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t SLOT_MFR  = slot_t'(COMMON_INTERVAL - 1);
  localparam slot_t SLOT_PROD = slot_t'(SLOT_COUNT - 1);

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    MODE_TELEMETRY = 2'd0,
    MODE_TX_SLOT   = 2'd1,
    MODE_RX_PAGE   = 2'd2,
    MODE_RESTART   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_SERIAL       = 3'd0,
    REG_FW_MINOR     = 3'd1,
    REG_HW_REV       = 3'd2,
    REG_MFR_ID       = 3'd3,
    REG_MODEL        = 3'd4,
    REG_ASSIST_MODES = 3'd5
  } reg_idx_t;

  localparam logic [7:0] PAGE_SPEED   = 8'h01;
  localparam logic [7:0] PAGE_DIST    = 8'h02;
  localparam logic [7:0] PAGE_BATT    = 8'h03;
  localparam logic [7:0] PAGE_CAPAB   = 8'h05;
  localparam logic [7:0] PAGE_DISPLAY = 8'h10;
  localparam logic [7:0] PAGE_MFR     = 8'h50;
  localparam logic [7:0] PAGE_PROD    = 8'h51;

  localparam logic [7:0] TRAVEL_UNSET = 8'hFF;
  localparam logic [6:0] MAX_CHARGE   = 7'd100;
  localparam logic [6:0] LOW_CHARGE   = 7'd5;
  localparam logic [2:0] MAX_ASSIST   = 3'd4;

  typedef struct packed {
    logic [31:0] serial_number;
    logic [7:0]  firmware_minor;
    logic [7:0]  hardware_revision;
    logic [15:0] manufacturer_id;
    logic [15:0] model_number;
    logic [2:0]  assist_modes_supported;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  battery_percent;
    logic [7:0]  assist_level_in;
    logic [7:0]  assist_percent;
    logic [23:0] odometer_in;
    logic [11:0] speed_in;
    logic [11:0] range_in;
    logic [7:0]  rx_page_number;
    logic [7:0]  rx_travel_byte;
  } item_t;

endpackage

/* hdl/lev_page_broadcast_formatter.sv */
// ----------------------------------------------------------------------------
// lev_page_broadcast_formatter
// light electric vehicle telemetry store and broadcast data page formatter
// ----------------------------------------------------------------------------
// a page request passes the input register, then the result register, before its page can leave
// throughput: one request per cycle while the result side is not stalled, set by the input and result registers
// requests without a page (telemetry, received page) pass the input register but skip the result register
// reset: synchronous active low rst_n clears telemetry, rotation counter and valids
// registers return to their reset values (hardware revision 1, manufacturer 63, model 2)
module lev_page_broadcast_formatter
  import lpbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_battery_percent,
  input  logic [7:0]         in_assist_level_in,
  input  logic [7:0]         in_assist_percent,
  input  logic [23:0]        in_odometer_in,
  input  logic [11:0]        in_speed_in,
  input  logic [11:0]        in_range_in,
  input  logic [7:0]         in_rx_page_number,
  input  logic [7:0]         in_rx_travel_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_page_payload,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t  cfg;
  item_t in_item;
  item_t s_item;
  logic  s_valid;
  logic  s_take;

  assign in_item.mode            = mode_t'(in_mode);
  assign in_item.battery_percent = in_battery_percent;
  assign in_item.assist_level_in = in_assist_level_in;
  assign in_item.assist_percent  = in_assist_percent;
  assign in_item.odometer_in     = in_odometer_in;
  assign in_item.speed_in        = in_speed_in;
  assign in_item.range_in        = in_range_in;
  assign in_item.rx_page_number  = in_rx_page_number;
  assign in_item.rx_travel_byte  = in_rx_travel_byte;

  lpbf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpbf_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s_valid  (s_valid),
    .s_item   (s_item),
    .s_take   (s_take)
  );

  lpbf_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .s_valid          (s_valid),
    .s_item           (s_item),
    .s_take           (s_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_page_payload (out_page_payload)
  );

endmodule

/* hdl/lpbf_regs.sv */
// ----------------------------------------------------------------------------
// lpbf_regs
// apb register file holding the product and manufacturer identification and the supported assist modes
// ----------------------------------------------------------------------------
module lpbf_regs
  import lpbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_SERIAL:       cfg_nxt.serial_number          = pwdata;
        REG_FW_MINOR:     cfg_nxt.firmware_minor         = pwdata[7:0];
        REG_HW_REV:       cfg_nxt.hardware_revision      = pwdata[7:0];
        REG_MFR_ID:       cfg_nxt.manufacturer_id        = pwdata[15:0];
        REG_MODEL:        cfg_nxt.model_number           = pwdata[15:0];
        REG_ASSIST_MODES: cfg_nxt.assist_modes_supported = pwdata[2:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SERIAL:       prdata = cfg_r.serial_number;
      REG_FW_MINOR:     prdata = {24'd0, cfg_r.firmware_minor};
      REG_HW_REV:       prdata = {24'd0, cfg_r.hardware_revision};
      REG_MFR_ID:       prdata = {16'd0, cfg_r.manufacturer_id};
      REG_MODEL:        prdata = {16'd0, cfg_r.model_number};
      REG_ASSIST_MODES: prdata = {29'd0, cfg_r.assist_modes_supported};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.serial_number          <= 32'd0;
      cfg_r.firmware_minor         <= 8'd0;
      cfg_r.hardware_revision      <= 8'd1;
      cfg_r.manufacturer_id        <= 16'd63;
      cfg_r.model_number           <= 16'd2;
      cfg_r.assist_modes_supported <= 3'd4;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/lpbf_in_stage.sv */
// ----------------------------------------------------------------------------
// lpbf_in_stage
// input register stage that captures one request per cycle while the held one is taken
// ----------------------------------------------------------------------------
module lpbf_in_stage
  import lpbf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  s_valid,
  output item_t s_item,
  input  logic  s_take
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_ready  = !valid_r || s_take;
  assign accept    = in_valid && in_ready;
  assign valid_nxt = accept || (valid_r && !s_take);
  assign s_valid   = valid_r;
  assign s_item    = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

/* hdl/lpbf_engine.sv */
// ----------------------------------------------------------------------------
// lpbf_engine
// telemetry state, page rotation counter, page builder and result register
// ----------------------------------------------------------------------------
module lpbf_engine
  import lpbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        s_valid,
  input  item_t       s_item,
  output logic        s_take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_page_payload
);

  logic [6:0]  charge_level_r,   charge_level_nxt;
  logic [2:0]  assist_level_r,   assist_level_nxt;
  logic [7:0]  assist_share_r,   assist_share_nxt;
  logic [23:0] distance_total_r, distance_total_nxt;
  logic [11:0] vehicle_speed_r,  vehicle_speed_nxt;
  logic [11:0] range_left_r,     range_left_nxt;
  slot_t       slot_r,           slot_nxt;
  logic        out_valid_r,      out_valid_nxt;
  logic [63:0] payload_r;

  logic        has_result;
  logic        out_free;
  logic [2:0]  rx_req;
  logic [7:0]  travel;
  logic [7:0]  speed_lo;
  logic [7:0]  speed_hi;
  logic [63:0] page_one;
  logic [63:0] page_two;
  logic [63:0] page_three;
  logic [63:0] page_five;
  logic [63:0] page_eighty;
  logic [63:0] page_eighty_one;
  logic [63:0] page_nxt;
  logic [7:0]  soc_byte;

  assign has_result = (s_item.mode == MODE_TX_SLOT) || (s_item.mode == MODE_RESTART);
  assign out_free   = !out_valid_r || out_ready;
  assign s_take     = s_valid && (!has_result || out_free);

  assign out_valid        = out_valid_r;
  assign out_page_payload = payload_r;

  // page assembly, byte 0 in the low bits
  assign travel   = {2'b00, assist_level_r, 3'b000};
  assign speed_lo = vehicle_speed_r[7:0];
  assign speed_hi = {4'hF, vehicle_speed_r[11:8]};
  assign soc_byte = {(charge_level_r < LOW_CHARGE), charge_level_r};

  assign page_one   = {speed_hi, speed_lo, 8'h00, 8'h00, 8'h00, travel, 8'h00, PAGE_SPEED};
  assign page_two   = {speed_hi, speed_lo, 4'hF, range_left_r[11:8], range_left_r[7:0],
                       distance_total_r[23:16], distance_total_r[15:8],
                       distance_total_r[7:0], PAGE_DIST};
  assign page_three = {speed_hi, speed_lo, assist_share_r, 8'h00, 8'h00, travel,
                       soc_byte, PAGE_BATT};
  assign page_five  = {8'hFF, 8'hFF, 8'hFF, 8'hF0, 8'h00,
                       {2'b00, cfg.assist_modes_supported, 3'b000}, 8'hFF, PAGE_CAPAB};
  assign page_eighty     = {cfg.model_number, cfg.manufacturer_id, cfg.hardware_revision,
                            8'hFF, 8'hFF, PAGE_MFR};
  assign page_eighty_one = {cfg.serial_number, cfg.firmware_minor, 8'hFF, 8'hFF, PAGE_PROD};

  always_comb begin
    if (s_item.mode == MODE_RESTART) begin
      page_nxt = page_one;
    end else begin
      case (slot_r[1:0])
        2'd0:    page_nxt = page_one;
        2'd1:    page_nxt = page_two;
        2'd2:    page_nxt = page_three;
        default: begin
          if (slot_r == SLOT_MFR) begin
            page_nxt = page_eighty;
          end else if (slot_r == SLOT_PROD) begin
            page_nxt = page_eighty_one;
          end else begin
            page_nxt = page_five;
          end
        end
      endcase
    end
  end

  assign rx_req = s_item.rx_travel_byte[5:3];

  always_comb begin
    charge_level_nxt   = charge_level_r;
    assist_level_nxt   = assist_level_r;
    assist_share_nxt   = assist_share_r;
    distance_total_nxt = distance_total_r;
    vehicle_speed_nxt  = vehicle_speed_r;
    range_left_nxt     = range_left_r;
    slot_nxt           = slot_r;
    if (s_take) begin
      case (s_item.mode)
        MODE_TELEMETRY: begin
          charge_level_nxt   = (s_item.battery_percent > {1'b0, MAX_CHARGE}) ?
                               MAX_CHARGE : s_item.battery_percent[6:0];
          assist_level_nxt   = (s_item.assist_level_in > {5'd0, MAX_ASSIST}) ?
                               MAX_ASSIST : s_item.assist_level_in[2:0];
          assist_share_nxt   = s_item.assist_percent;
          distance_total_nxt = s_item.odometer_in;
          vehicle_speed_nxt  = s_item.speed_in;
          range_left_nxt     = s_item.range_in;
        end
        MODE_TX_SLOT: begin
          slot_nxt = (slot_r == SLOT_PROD) ? '0 : slot_r + slot_t'(1);
        end
        MODE_RX_PAGE: begin
          if ((s_item.rx_page_number == PAGE_DISPLAY) &&
              (s_item.rx_travel_byte != TRAVEL_UNSET)) begin
            assist_level_nxt = (rx_req > MAX_ASSIST) ? MAX_ASSIST : rx_req;
          end
        end
        MODE_RESTART: begin
          slot_nxt = '0;
        end
        default: begin
          slot_nxt = slot_r;
        end
      endcase
    end
  end

  always_comb begin
    if (s_take && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charge_level_r   <= '0;
      assist_level_r   <= '0;
      assist_share_r   <= '0;
      distance_total_r <= '0;
      vehicle_speed_r  <= '0;
      range_left_r     <= '0;
      slot_r           <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      charge_level_r   <= charge_level_nxt;
      assist_level_r   <= assist_level_nxt;
      assist_share_r   <= assist_share_nxt;
      distance_total_r <= distance_total_nxt;
      vehicle_speed_r  <= vehicle_speed_nxt;
      range_left_r     <= range_left_nxt;
      slot_r           <= slot_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take && has_result) begin
      payload_r <= page_nxt;
    end
  end

endmodule

/* hdl/lpbf_checker.sv */
// ----------------------------------------------------------------------------
// lpbf_checker
// port-level checks on the broadcast page formatter
// ----------------------------------------------------------------------------
module lpbf_checker
  import lpbf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_page_payload
);

  // a stalled page holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_page_payload))
    else $error("page changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_page_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_page_payload[7:0] == PAGE_SPEED) ||
                  (out_page_payload[7:0] == PAGE_DIST) ||
                  (out_page_payload[7:0] == PAGE_BATT) ||
                  (out_page_payload[7:0] == PAGE_CAPAB) ||
                  (out_page_payload[7:0] == PAGE_MFR) ||
                  (out_page_payload[7:0] == PAGE_PROD))
    else $error("unknown page number");

  a_speed_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_page_payload[7:0] == PAGE_SPEED) |->
      out_page_payload[63:60] == 4'hF && out_page_payload[39:24] == 16'h0000)
    else $error("speed page reserved bits wrong");

  a_capab_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_page_payload[7:0] == PAGE_CAPAB) |->
      out_page_payload[63:32] == 32'hFFFF_FFF0 && out_page_payload[15:8] == 8'hFF)
    else $error("capabilities page fixed bytes wrong");

endmodule

bind lev_page_broadcast_formatter lpbf_checker u_lpbf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_page_payload (out_page_payload)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the light electric vehicle broadcast page formatter:
// telemetry, received display pages and restarts are driven over valid/ready,
// every transmit slot is predicted from an in-bench copy of the telemetry and
// the page rotation, and each page read out is compared with the oldest one
// predicted. registers are swept over the apb port with read-back while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import lpbf_pkg::*;

  localparam int LIMIT = 500000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_mode;
  logic [7:0]         in_battery_percent;
  logic [7:0]         in_assist_level_in;
  logic [7:0]         in_assist_percent;
  logic [23:0]        in_odometer_in;
  logic [11:0]        in_speed_in;
  logic [11:0]        in_range_in;
  logic [7:0]         in_rx_page_number;
  logic [7:0]         in_rx_travel_byte;
  logic               out_valid;
  logic               out_ready;
  logic [63:0]        out_page_payload;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lev_page_broadcast_formatter u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_battery_percent (in_battery_percent),
    .in_assist_level_in (in_assist_level_in),
    .in_assist_percent  (in_assist_percent),
    .in_odometer_in     (in_odometer_in),
    .in_speed_in        (in_speed_in),
    .in_range_in        (in_range_in),
    .in_rx_page_number  (in_rx_page_number),
    .in_rx_travel_byte  (in_rx_travel_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_page_payload   (out_page_payload),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // register copies
  logic [31:0] ser_no    = 32'd0;
  logic [7:0]  fw_minor  = 8'd0;
  logic [7:0]  hw_rev    = 8'd1;
  logic [15:0] mfr_id    = 16'd63;
  logic [15:0] model_no  = 16'd2;
  logic [2:0]  modes_sup = 3'd4;

  // telemetry and rotation copies
  logic [6:0]  charge_lvl = '0;
  logic [2:0]  assist_lvl = '0;
  logic [7:0]  assist_shr = '0;
  logic [23:0] odo_total  = '0;
  logic [11:0] veh_speed  = '0;
  logic [11:0] rng_left   = '0;
  slot_t       slot_cnt   = '0;

  logic [63:0] exp_pages[$];
  int          errors = 0;
  bit          steady = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("FAIL lev_page_broadcast_formatter");
    $finish;
  end

  function automatic logic [63:0] speed_page(logic [7:0] num, logic [7:0] b1, logic [7:0] b5);
    return {4'hF, veh_speed[11:8], veh_speed[7:0], b5, 8'h00, 8'h00,
            {2'b00, assist_lvl, 3'b000}, b1, num};
  endfunction

  function automatic logic [63:0] dist_page();
    return {4'hF, veh_speed[11:8], veh_speed[7:0], 4'hF, rng_left[11:8], rng_left[7:0],
            odo_total, PAGE_DIST};
  endfunction

  function automatic logic [63:0] battery_page();
    return speed_page(PAGE_BATT, {charge_lvl < LOW_CHARGE, charge_lvl}, assist_shr);
  endfunction

  function automatic logic [63:0] capab_page();
    return {24'hFFFFFF, 8'hF0, 8'h00, {2'b00, modes_sup, 3'b000}, 8'hFF, PAGE_CAPAB};
  endfunction

  function automatic logic [63:0] mfr_page();
    return {model_no, mfr_id, hw_rev, 8'hFF, 8'hFF, PAGE_MFR};
  endfunction

  function automatic logic [63:0] product_page();
    return {ser_no, fw_minor, 8'hFF, 8'hFF, PAGE_PROD};
  endfunction

  task automatic predict_request(item_t it);
    logic [63:0] pg;
    logic [2:0]  req;
    case (it.mode)
      MODE_TELEMETRY: begin
        charge_lvl = (it.battery_percent > MAX_CHARGE) ? MAX_CHARGE : it.battery_percent[6:0];
        assist_lvl = (it.assist_level_in > MAX_ASSIST) ? MAX_ASSIST : it.assist_level_in[2:0];
        assist_shr = it.assist_percent;
        odo_total  = it.odometer_in;
        veh_speed  = it.speed_in;
        rng_left   = it.range_in;
      end
      MODE_RX_PAGE: begin
        if (it.rx_page_number == PAGE_DISPLAY && it.rx_travel_byte != TRAVEL_UNSET) begin
          req = it.rx_travel_byte[5:3];
          assist_lvl = (req > MAX_ASSIST) ? MAX_ASSIST : req;
        end
      end
      MODE_RESTART: begin
        slot_cnt = '0;
        exp_pages.push_back(speed_page(PAGE_SPEED, 8'h00, 8'h00));
      end
      default: begin
        case (slot_cnt[1:0])
          2'd0: pg = speed_page(PAGE_SPEED, 8'h00, 8'h00);
          2'd1: pg = dist_page();
          2'd2: pg = battery_page();
          default: begin
            if (slot_cnt == SLOT_MFR) pg = mfr_page();
            else if (slot_cnt == SLOT_PROD) pg = product_page();
            else pg = capab_page();
          end
        endcase
        exp_pages.push_back(pg);
        slot_cnt = (slot_cnt == SLOT_PROD) ? slot_t'(0) : slot_t'(slot_cnt + 1'b1);
      end
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_pages.size() == 0) begin
        $display("%0t: unexpected page: expected none, got %h", $time, out_page_payload);
        errors++;
      end else begin
        if (out_page_payload !== exp_pages[0]) begin
          $display("%0t: page mismatch: expected %h, got %h", $time, exp_pages[0],
                   out_page_payload);
          errors++;
        end
        void'(exp_pages.pop_front());
      end
    end
  end

  // result side stalls
  initial begin
    int n;
    out_ready = 1'b1;
    forever begin
      if (!steady && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 14);
        repeat (n) begin
          @(negedge clk);
          out_ready = steady;
        end
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          @(negedge clk);
          out_ready = 1'b1;
        end
      end
    end
  end

  task automatic send_item(item_t it);
    int n;
    if (!steady && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 14);
      repeat (n) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_mode            = it.mode;
    in_battery_percent = it.battery_percent;
    in_assist_level_in = it.assist_level_in;
    in_assist_percent  = it.assist_percent;
    in_odometer_in     = it.odometer_in;
    in_speed_in        = it.speed_in;
    in_range_in        = it.range_in;
    in_rx_page_number  = it.rx_page_number;
    in_rx_travel_byte  = it.rx_travel_byte;
    in_valid           = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(it);
  endtask

  task automatic wait_drained(int settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (exp_pages.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_access(reg_idx_t idx, logic [31:0] val);
    logic [31:0] kept;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SERIAL:       begin ser_no    = val;       kept = val;                 end
      REG_FW_MINOR:     begin fw_minor  = val[7:0];  kept = {24'h0, val[7:0]};   end
      REG_HW_REV:       begin hw_rev    = val[7:0];  kept = {24'h0, val[7:0]};   end
      REG_MFR_ID:       begin mfr_id    = val[15:0]; kept = {16'h0, val[15:0]};  end
      REG_MODEL:        begin model_no  = val[15:0]; kept = {16'h0, val[15:0]};  end
      REG_ASSIST_MODES: begin modes_sup = val[2:0];  kept = {29'h0, val[2:0]};   end
      default:          kept = '0;
    endcase
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== kept) begin
      $display("%0t: register %0d read-back: expected %h, got %h", $time, idx, kept, prdata);
      errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_registers(logic [31:0] s, logic [7:0] fw, logic [7:0] hw,
                                logic [15:0] mf, logic [15:0] md, logic [2:0] am);
    cfg_access(REG_SERIAL, s);
    cfg_access(REG_FW_MINOR, {24'h0, fw});
    cfg_access(REG_HW_REV, {24'h0, hw});
    cfg_access(REG_MFR_ID, {16'h0, mf});
    cfg_access(REG_MODEL, {16'h0, md});
    cfg_access(REG_ASSIST_MODES, {29'h0, am});
  endtask

  function automatic item_t mk(mode_t m);
    item_t it;
    it.battery_percent = 8'($urandom);
    it.assist_level_in = 8'($urandom);
    it.assist_percent  = 8'($urandom);
    it.odometer_in     = 24'($urandom);
    it.speed_in        = 12'($urandom);
    it.range_in        = 12'($urandom);
    it.rx_page_number  = 8'($urandom);
    it.rx_travel_byte  = 8'($urandom);
    it.mode            = m;
    return it;
  endfunction

  function automatic item_t telemetry_item(logic [7:0] bat, logic [7:0] lvl, logic [7:0] shr,
                                           logic [23:0] odo, logic [11:0] spd,
                                           logic [11:0] rng);
    item_t it;
    it = mk(MODE_TELEMETRY);
    it.battery_percent = bat;
    it.assist_level_in = lvl;
    it.assist_percent  = shr;
    it.odometer_in     = odo;
    it.speed_in        = spd;
    it.range_in        = rng;
    return it;
  endfunction

  function automatic item_t rx_item(logic [7:0] pg, logic [7:0] travel);
    item_t it;
    it = mk(MODE_RX_PAGE);
    it.rx_page_number = pg;
    it.rx_travel_byte = travel;
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      it = mk(MODE_TELEMETRY);
      if ($urandom_range(0, 3) == 0) it.battery_percent = 8'($urandom_range(0, 6));
      if ($urandom_range(0, 1) == 0) it.assist_level_in = 8'($urandom_range(0, 7));
    end else if (r < 85) begin
      it = mk(MODE_TX_SLOT);
    end else if (r < 98) begin
      it = mk(MODE_RX_PAGE);
      if ($urandom_range(0, 3) != 0) it.rx_page_number = PAGE_DISPLAY;
      if ($urandom_range(0, 4) == 0) it.rx_travel_byte = TRAVEL_UNSET;
    end else begin
      it = mk(MODE_RESTART);
    end
    return it;
  endfunction

  task automatic test_directed();
    send_item(mk(MODE_TX_SLOT));
    send_item(telemetry_item(8'd0, 8'd0, 8'd0, 24'd0, 12'd0, 12'd0));
    send_item(mk(MODE_TX_SLOT));
    send_item(mk(MODE_TX_SLOT));
    send_item(mk(MODE_TX_SLOT));
    send_item(telemetry_item(8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, 12'hFFF, 12'hFFF));
    send_item(mk(MODE_TX_SLOT));
    send_item(mk(MODE_TX_SLOT));
    send_item(mk(MODE_TX_SLOT));
    // low charge flag
    send_item(telemetry_item(8'd4, 8'd5, 8'd254, 24'h123456, 12'hABC, 12'd1));
    send_item(mk(MODE_RESTART));
    send_item(mk(MODE_TX_SLOT));
    send_item(mk(MODE_TX_SLOT));
    send_item(mk(MODE_TX_SLOT));
    send_item(telemetry_item(8'd5, 8'd3, 8'd100, 24'd0, 12'd1, 12'd0));
    send_item(rx_item(PAGE_DISPLAY, TRAVEL_UNSET));
    send_item(rx_item(PAGE_DISPLAY, 8'b0011_1000));
    send_item(rx_item(8'h20, 8'h00));
    send_item(mk(MODE_TX_SLOT));
    send_item(mk(MODE_TX_SLOT));
    send_item(rx_item(PAGE_DISPLAY, 8'b1101_1111));
    send_item(mk(MODE_TX_SLOT));
    send_item(mk(MODE_TX_SLOT));
    send_item(telemetry_item(8'd101, 8'd4, 8'd0, 24'd1, 12'd2, 12'd3));
    send_item(mk(MODE_RESTART));
  endtask

  // full rotation under several register settings, product and manufacturer pages included
  task automatic test_page_rotation();
    for (int s = 0; s < 4; s++) begin
      wait_drained(4);
      case (s)
        0: load_registers(32'h0, 8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0);
        1: load_registers(32'hFFFFFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
        default: load_registers($urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                                16'($urandom), 3'($urandom));
      endcase
      send_item(mk(MODE_RESTART));
      for (int k = 0; k < 100; k++) begin
        if (k % 5 == 4) send_item(rand_item());
        else send_item(mk(MODE_TX_SLOT));
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int k = 0; k < 1200; k++) begin
      if (k % 300 == 299) wait_drained(0);
      send_item(rand_item());
    end
  endtask

  task automatic test_streaming();
    wait_drained(4);
    steady = 1;
    for (int k = 0; k < 150; k++) send_item(rand_item());
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_mode            = '0;
    in_battery_percent = '0;
    in_assist_level_in = '0;
    in_assist_percent  = '0;
    in_odometer_in     = '0;
    in_speed_in        = '0;
    in_range_in        = '0;
    in_rx_page_number  = '0;
    in_rx_travel_byte  = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_page_rotation();
    test_random_traffic();
    test_streaming();
    wait_drained(8);

    if (errors == 0 && exp_pages.size() == 0) begin
      $display("PASS lev_page_broadcast_formatter");
    end else begin
      $display("FAIL lev_page_broadcast_formatter");
    end
    $finish;
  end

endmodule
